[hdl/mmb_pkg.sv]
// shared constants, types and arithmetic helpers for the model matrix builder
package mmb_pkg;

  localparam int DW            = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WQ            = 30;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [26:0] DEG2RAD = 27'(((PI_Q60 / 64'd180) + (64'd1 << 27)) >> 28);
  localparam logic [30:0] W_ONE   = 31'h4000_0000;

  localparam int SIN_N = 6;
  localparam int COS_N = 7;

  localparam logic [32:0] SIN_M [SIN_N] = '{
    33'(((64'd1 << 40) + 64'd155) / 64'd156),
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam int SIN_SH [SIN_N] = '{40, 39, 39, 38, 37, 35};

  localparam logic [32:0] COS_M [COS_N] = '{
    33'(((64'd1 << 40) + 64'd181) / 64'd182),
    33'(((64'd1 << 40) + 64'd131) / 64'd132),
    33'(((64'd1 << 39) + 64'd89) / 64'd90),
    33'(((64'd1 << 38) + 64'd55) / 64'd56),
    33'(((64'd1 << 37) + 64'd29) / 64'd30),
    33'(((64'd1 << 36) + 64'd11) / 64'd12),
    33'(((64'd1 << 33) + 64'd1) / 64'd2)
  };
  localparam int COS_SH [COS_N] = '{40, 40, 39, 38, 37, 36, 33};

  localparam int ANG_LAT   = 7;
  localparam int SER_LAT   = 2 * COS_N + 1;
  localparam int ROT_LAT   = 3;
  localparam int SCL_LAT   = 2;
  localparam int FRONT_LAT = ANG_LAT + SER_LAT + ROT_LAT;
  localparam int PIPE_LAT  = FRONT_LAT + SCL_LAT;

  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  typedef logic [2:0][2:0][32:0] rot_t;
  typedef logic [2:0][2:0][31:0] mat_t;
  typedef logic [2:0][31:0]      vec3_t;

  // shift right by 30, halves away from zero
  function automatic logic signed [63:0] rnd_q30(input logic signed [65:0] p);
    logic signed [65:0] adj;
    adj = p + 66'sd536870912 - signed'({65'd0, p[65]});
    return 64'(adj >>> WQ);
  endfunction

  function automatic logic signed [31:0] rm32(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] prod;
    prod = 64'(a) * 64'(b);
    return 32'(rnd_q30(66'(prod)));
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return 32'(v);
  endfunction

endpackage

[hdl/model_matrix_builder.sv]
// top level: euler zyx model matrix builder with row output buffer
// An item is three Euler angles in degrees with a translation and a scale, all signed
// fixed point with FRAC_BITS fraction bits; it yields the 4x4 matrix T*R*S as four row
// transfers, row 0 first, last_row_o set on row 3. The first row comes out after the
// 27 pipeline stages and the row buffer register. The pipeline takes an item every
// cycle when not stalled, but the row buffer sends one row per cycle while out_stall_i
// is low, so the sustained rate is one item per four row transfers; in_stall_o rises
// when a finished matrix waits in the last stage while the buffer is still sending rows.
module model_matrix_builder #(
  parameter int FRAC_BITS = mmb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] angle_x_deg_i,
  input  logic signed [31:0] angle_y_deg_i,
  input  logic signed [31:0] angle_z_deg_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] shift_z_i,
  input  logic signed [31:0] factor_x_i,
  input  logic signed [31:0] factor_y_i,
  input  logic signed [31:0] factor_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  row_index_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic               last_row_o
);

  localparam int          LAT   = mmb_pkg::PIPE_LAT;
  localparam int          FLAT  = mmb_pkg::FRONT_LAT;
  localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  typedef struct packed {
    mmb_pkg::vec3_t sh;
    mmb_pkg::vec3_t fac;
  } side_t;

  logic           en, take, out_xfer, done, last_r;
  logic [LAT-1:0] vld_q;
  side_t          dly_q [FLAT];
  side_t          side_in;

  logic        [30:0] x_x, x_y, x_z;
  logic        [31:0] x2_x, x2_y, x2_z;
  mmb_pkg::quad_e     qd_x, qd_y, qd_z;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  mmb_pkg::rot_t      rot;
  mmb_pkg::mat_t      mat;
  mmb_pkg::vec3_t     shf;

  mmb_pkg::mat_t  mat_q;
  mmb_pkg::vec3_t shb_q;
  logic [1:0]     row_d, row_q;
  logic           buf_v_d, buf_v_q;

  assign out_xfer   = buf_v_q && !out_stall_i;
  assign done       = out_xfer && (row_q == mmb_pkg::ROW_LAST);
  assign take       = vld_q[LAT-1] && (!buf_v_q || done);
  assign en         = !vld_q[LAT-1] || take;
  assign in_stall_o = !en;

  assign side_in = '{sh:  {shift_z_i, shift_y_i, shift_x_i},
                     fac: {factor_z_i, factor_y_i, factor_x_i}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= side_in;
      for (int i = 1; i < FLAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  mmb_angle #(.FRAC_BITS(FRAC_BITS)) u_ang_x (
    .clk_i, .en_i(en), .angle_i(angle_x_deg_i), .x_o(x_x), .x2_o(x2_x), .quad_o(qd_x)
  );
  mmb_angle #(.FRAC_BITS(FRAC_BITS)) u_ang_y (
    .clk_i, .en_i(en), .angle_i(angle_y_deg_i), .x_o(x_y), .x2_o(x2_y), .quad_o(qd_y)
  );
  mmb_angle #(.FRAC_BITS(FRAC_BITS)) u_ang_z (
    .clk_i, .en_i(en), .angle_i(angle_z_deg_i), .x_o(x_z), .x2_o(x2_z), .quad_o(qd_z)
  );

  mmb_series u_ser_x (
    .clk_i, .en_i(en), .x_i(x_x), .x2_i(x2_x), .quad_i(qd_x), .sin_o(sx), .cos_o(cx)
  );
  mmb_series u_ser_y (
    .clk_i, .en_i(en), .x_i(x_y), .x2_i(x2_y), .quad_i(qd_y), .sin_o(sy), .cos_o(cy)
  );
  mmb_series u_ser_z (
    .clk_i, .en_i(en), .x_i(x_z), .x2_i(x2_z), .quad_i(qd_z), .sin_o(sz), .cos_o(cz)
  );

  mmb_rot u_rot (
    .clk_i, .en_i(en),
    .sx_i(sx), .cx_i(cx), .sy_i(sy), .cy_i(cy), .sz_i(sz), .cz_i(cz),
    .rot_o(rot)
  );

  mmb_scale u_scale (
    .clk_i, .en_i(en),
    .rot_i(rot), .fac_i(dly_q[FLAT-1].fac), .shift_i(dly_q[FLAT-1].sh),
    .mat_o(mat), .shift_o(shf)
  );

  // row buffer
  always_comb begin
    buf_v_d = buf_v_q;
    row_d   = row_q;
    if (take) begin
      buf_v_d = 1'b1;
      row_d   = '0;
    end else if (done) begin
      buf_v_d = 1'b0;
    end else if (out_xfer) begin
      row_d = row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_v_q <= 1'b0;
      row_q   <= '0;
    end else begin
      buf_v_q <= buf_v_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mat_q <= mat;
      shb_q <= shf;
    end
  end

  assign last_r      = (row_q == mmb_pkg::ROW_LAST);
  assign out_valid_o = buf_v_q;
  assign row_index_o = row_q;
  assign last_row_o  = last_r;
  assign col0_o      = last_r ? '0 : mat_q[row_q][0];
  assign col1_o      = last_r ? '0 : mat_q[row_q][1];
  assign col2_o      = last_r ? '0 : mat_q[row_q][2];
  assign col3_o      = last_r ? ONE_Q : shb_q[row_q];

`ifndef NO_ASSERTIONS
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (row_q != mmb_pkg::ROW_LAST) |=> buf_v_q && (row_q == $past(row_q) + 2'd1))
    else $error("row counter did not advance after a row transfer");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld_q[LAT-1] && buf_v_q && !done)
    else $error("input stalled without a waiting matrix");

  a_hold_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_v_q && !out_xfer |=> buf_v_q && $stable(row_q))
    else $error("row buffer changed while its transfer was stalled");

  a_new_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> buf_v_q && (row_q == 2'd0))
    else $error("new matrix did not start at row 0");
`endif

endmodule

[hdl/mmb_angle.sv]
// angle reduction modulo 360 degrees, quadrant split and conversion to radians
module mmb_angle #(
  parameter int FRAC_BITS = mmb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] angle_i,
  output logic        [30:0] x_o,
  output logic        [31:0] x2_o,
  output mmb_pkg::quad_e     quad_o
);

  localparam logic [63:0] FULL  = 64'd360 << FRAC_BITS;
  localparam logic [63:0] QUART = 64'd90 << FRAC_BITS;
  localparam int          RW    = $clog2(FULL);
  localparam int          RW1   = RW + 1;
  localparam int          XW    = RW - 2;
  localparam int          P     = RW - 2;
  localparam int          QW    = 34 - RW;
  localparam logic [32:0] RM    = 33'((64'd1 << (32 + P)) / FULL);
  localparam logic [63:0] OFS   = 64'h8000_0000 % FULL;

  logic [31:0]    u;
  logic [64:0]    prod1;
  logic [31:0]    u1_q, u2_q;
  logic [QW-1:0]  q1_q;
  logic [32:0]    m2_q, r0;
  logic [RW-1:0]  r3_d, r3_q, r4_d, r4_q;
  logic [XW-1:0]  rem5_d, rem5_q;
  mmb_pkg::quad_e quad5_d, quad5_q, quad6_q, quad7_q;
  logic [30:0]    x6_q, x7_q;
  logic [31:0]    x2_7_q;

  assign u     = angle_i ^ 32'h8000_0000;
  assign prod1 = 65'(u) * 65'(RM);
  assign r0    = 33'(u2_q) - m2_q;

  always_comb begin
    if (64'(r0) >= 2 * FULL) begin
      r3_d = RW'(64'(r0) - 2 * FULL);
    end else if (64'(r0) >= FULL) begin
      r3_d = RW'(64'(r0) - FULL);
    end else begin
      r3_d = RW'(r0);
    end
  end

  always_comb begin
    if (r3_q >= RW'(OFS)) begin
      r4_d = RW'(RW1'(r3_q) - RW1'(OFS));
    end else begin
      r4_d = RW'(RW1'(r3_q) + RW1'(FULL - OFS));
    end
  end

  always_comb begin
    priority if (64'(r4_q) >= 3 * QUART) begin
      quad5_d = mmb_pkg::QUAD_3;
      rem5_d  = XW'(64'(r4_q) - 3 * QUART);
    end else if (64'(r4_q) >= 2 * QUART) begin
      quad5_d = mmb_pkg::QUAD_2;
      rem5_d  = XW'(64'(r4_q) - 2 * QUART);
    end else if (64'(r4_q) >= QUART) begin
      quad5_d = mmb_pkg::QUAD_1;
      rem5_d  = XW'(64'(r4_q) - QUART);
    end else begin
      quad5_d = mmb_pkg::QUAD_0;
      rem5_d  = XW'(r4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q    <= u;
      q1_q    <= QW'(prod1 >> (32 + P));
      u2_q    <= u1_q;
      m2_q    <= 33'(64'(q1_q) * FULL);
      r3_q    <= r3_d;
      r4_q    <= r4_d;
      rem5_q  <= rem5_d;
      quad5_q <= quad5_d;
      x6_q    <= 31'((64'(rem5_q) * 64'(mmb_pkg::DEG2RAD)) >> (FRAC_BITS + 2));
      quad6_q <= quad5_q;
      x7_q    <= x6_q;
      x2_7_q  <= 32'((64'(x6_q) * 64'(x6_q)) >> 30);
      quad7_q <= quad6_q;
    end
  end

  assign x_o    = x7_q;
  assign x2_o   = x2_7_q;
  assign quad_o = quad7_q;

endmodule

[hdl/mmb_series.sv]
// pipelined sine and cosine series with quadrant mapping
module mmb_series (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic        [30:0] x_i,
  input  logic        [31:0] x2_i,
  input  mmb_pkg::quad_e     quad_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int CN = mmb_pkg::COS_N;
  localparam int SN = mmb_pkg::SIN_N;

  typedef struct packed {
    logic [30:0]    x;
    logic [31:0]    x2;
    mmb_pkg::quad_e quad;
  } ser_bus_t;

  ser_bus_t           in_bus;
  ser_bus_t           bus_a_q [CN];
  ser_bus_t           bus_b_q [CN];
  logic        [31:0] cv_q [CN];
  logic        [30:0] ct_q [CN];
  logic        [31:0] sv_q [SN];
  logic        [30:0] st_q [SN];
  logic        [30:0] sf_q;
  logic signed [31:0] sv, cv, sin_d, cos_d, sin_q, cos_q;
  mmb_pkg::quad_e     quad_f;

  assign in_bus = '{x: x_i, x2: x2_i, quad: quad_i};

  for (genvar k = 0; k < CN; k++) begin : g_step
    ser_bus_t    src;
    logic [30:0] ct_src;
    logic [30:0] st_src;
    logic [64:0] cprod;
    logic [32:0] csub;

    if (k == 0) begin : g_first
      assign src    = in_bus;
      assign ct_src = mmb_pkg::W_ONE;
      assign st_src = mmb_pkg::W_ONE;
    end else begin : g_next
      assign src    = bus_b_q[k-1];
      assign ct_src = ct_q[k-1];
      assign st_src = st_q[k-1];
    end

    assign cprod = 65'(cv_q[k]) * 65'(mmb_pkg::COS_M[k]);
    assign csub  = 33'(cprod >> mmb_pkg::COS_SH[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bus_a_q[k] <= src;
        cv_q[k]    <= 32'((64'(src.x2) * 64'(ct_src)) >> 30);
        bus_b_q[k] <= bus_a_q[k];
        ct_q[k]    <= (csub > 33'(mmb_pkg::W_ONE)) ? '0 :
                      31'(33'(mmb_pkg::W_ONE) - csub);
      end
    end

    if (k < SN) begin : g_sin
      logic [64:0] sprod;
      logic [32:0] ssub;

      assign sprod = 65'(sv_q[k]) * 65'(mmb_pkg::SIN_M[k]);
      assign ssub  = 33'(sprod >> mmb_pkg::SIN_SH[k]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sv_q[k] <= 32'((64'(src.x2) * 64'(st_src)) >> 30);
          st_q[k] <= (ssub > 33'(mmb_pkg::W_ONE)) ? '0 :
                     31'(33'(mmb_pkg::W_ONE) - ssub);
        end
      end
    end else begin : g_sin_fin
      logic [61:0] sp_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sp_q <= 62'(64'(src.x) * 64'(st_src));
          sf_q <= 31'(sp_q >> 30);
        end
      end
    end
  end

  assign sv     = 32'(sf_q);
  assign cv     = 32'(ct_q[CN-1]);
  assign quad_f = bus_b_q[CN-1].quad;

  always_comb begin
    unique case (quad_f)
      mmb_pkg::QUAD_0: begin
        sin_d = sv;
        cos_d = cv;
      end
      mmb_pkg::QUAD_1: begin
        sin_d = cv;
        cos_d = -sv;
      end
      mmb_pkg::QUAD_2: begin
        sin_d = -sv;
        cos_d = -cv;
      end
      default: begin
        sin_d = -cv;
        cos_d = sv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

[hdl/mmb_rot.sv]
// rotation matrix rz*ry*rx from sines and cosines
module mmb_rot (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] sx_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] sz_i,
  input  logic signed [31:0] cz_i,
  output mmb_pkg::rot_t      rot_o
);

  logic signed [31:0] czsy_q, szsy_q, r00_q, r10_q, szcx_q, szsx_q, czcx_q, czsx_q;
  logic signed [31:0] r21_q, r22_q, sx1_q, cx1_q, sy1_q;
  logic signed [31:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [31:0] r00b_q, r10b_q, szcxb_q, szsxb_q, czcxb_q, czsxb_q;
  logic signed [31:0] r21b_q, r22b_q, sy2_q;
  mmb_pkg::rot_t      rot_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czsy_q  <= mmb_pkg::rm32(cz_i, sy_i);
      szsy_q  <= mmb_pkg::rm32(sz_i, sy_i);
      r00_q   <= mmb_pkg::rm32(cz_i, cy_i);
      r10_q   <= mmb_pkg::rm32(sz_i, cy_i);
      szcx_q  <= mmb_pkg::rm32(sz_i, cx_i);
      szsx_q  <= mmb_pkg::rm32(sz_i, sx_i);
      czcx_q  <= mmb_pkg::rm32(cz_i, cx_i);
      czsx_q  <= mmb_pkg::rm32(cz_i, sx_i);
      r21_q   <= mmb_pkg::rm32(cy_i, sx_i);
      r22_q   <= mmb_pkg::rm32(cy_i, cx_i);
      sx1_q   <= sx_i;
      cx1_q   <= cx_i;
      sy1_q   <= sy_i;

      p1_q    <= mmb_pkg::rm32(czsy_q, sx1_q);
      p2_q    <= mmb_pkg::rm32(czsy_q, cx1_q);
      p3_q    <= mmb_pkg::rm32(szsy_q, sx1_q);
      p4_q    <= mmb_pkg::rm32(szsy_q, cx1_q);
      r00b_q  <= r00_q;
      r10b_q  <= r10_q;
      szcxb_q <= szcx_q;
      szsxb_q <= szsx_q;
      czcxb_q <= czcx_q;
      czsxb_q <= czsx_q;
      r21b_q  <= r21_q;
      r22b_q  <= r22_q;
      sy2_q   <= sy1_q;

      rot_q[0][0] <= 33'(r00b_q);
      rot_q[0][1] <= 33'(p1_q) - 33'(szcxb_q);
      rot_q[0][2] <= 33'(p2_q) + 33'(szsxb_q);
      rot_q[1][0] <= 33'(r10b_q);
      rot_q[1][1] <= 33'(p3_q) + 33'(czcxb_q);
      rot_q[1][2] <= 33'(p4_q) - 33'(czsxb_q);
      rot_q[2][0] <= -(33'(sy2_q));
      rot_q[2][1] <= 33'(r21b_q);
      rot_q[2][2] <= 33'(r22b_q);
    end
  end

  assign rot_o = rot_q;

endmodule

[hdl/mmb_scale.sv]
// per-column scaling of the rotation with rounding and saturation
module mmb_scale (
  input  logic           clk_i,
  input  logic           en_i,
  input  mmb_pkg::rot_t  rot_i,
  input  mmb_pkg::vec3_t fac_i,
  input  mmb_pkg::vec3_t shift_i,
  output mmb_pkg::mat_t  mat_o,
  output mmb_pkg::vec3_t shift_o
);

  logic signed [64:0] prod_q [3][3];
  mmb_pkg::mat_t      mat_q;
  mmb_pkg::vec3_t     sh1_q, sh2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= 65'($signed(rot_i[i][j])) * 65'($signed(fac_i[j]));
          mat_q[i][j]  <= mmb_pkg::sat32(mmb_pkg::rnd_q30(66'(prod_q[i][j])));
        end
      end
      sh1_q <= shift_i;
      sh2_q <= sh1_q;
    end
  end

  assign mat_o   = mat_q;
  assign shift_o = sh2_q;

endmodule

[sim/testbench.sv]
// testbench for the model matrix builder: directed table and random items checked against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int N_RANDOM = 300;
  localparam int LIMIT = 200000;
  localparam longint PI_Q60_C = 64'h3243F6A8885A308D;
  localparam longint DEG_RAD = ((PI_Q60_C / 180) + (64'd1 << 27)) >>> 28;
  localparam longint WONE = 64'd1 << 30;

  typedef struct {
    logic signed [31:0] ang [3];
    logic signed [31:0] shf [3];
    logic signed [31:0] fac [3];
  } item_t;

  typedef struct {
    logic [1:0] row;
    logic signed [31:0] c [4];
    logic last;
  } row_t;

  typedef struct {
    item_t it;
    logic has_exp;
    logic signed [31:0] diag [3];
  } dir_t;

  logic clk = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0, last_row_o;
  logic signed [31:0] ax = 0, ay = 0, az = 0, tx = 0, ty = 0, tz = 0, fx = 0, fy = 0, fz = 0;
  logic [1:0] row_index_o;
  logic signed [31:0] col0_o, col1_o, col2_o, col3_o;

  row_t rows_due [$];
  int errors = 0, sent = 0, rows_seen = 0;
  longint cycles = 0;
  bit sending_done = 0, hold_req = 0, no_idle = 0;

  model_matrix_builder dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .angle_x_deg_i(ax), .angle_y_deg_i(ay), .angle_z_deg_i(az),
    .shift_x_i(tx), .shift_y_i(ty), .shift_z_i(tz),
    .factor_x_i(fx), .factor_y_i(fy), .factor_z_i(fz),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .row_index_o(row_index_o), .col0_o(col0_o), .col1_o(col1_o), .col2_o(col2_o),
    .col3_o(col3_o), .last_row_o(last_row_o)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  localparam int SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
  localparam int COS_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

  function automatic longint taylor(longint x2, bit is_cos);
    longint t, sub, d;
    int n;
    t = WONE;
    n = is_cos ? 7 : 6;
    for (int i = 0; i < n; i++) begin
      d = is_cos ? longint'(COS_DIV[i]) : longint'(SIN_DIV[i]);
      sub = ((x2 * t) >>> 30) / d;
      t = (sub > WONE) ? 0 : WONE - sub;
    end
    return t;
  endfunction

  function automatic void trig(logic signed [31:0] a, output longint s, output longint c);
    longint full, quarter, r, q, rem, x, x2, sv, cv;
    logic [127:0] wide;
    full = longint'(360) << FB;
    quarter = longint'(90) << FB;
    r = longint'(a) % full;
    if (r < 0) r += full;
    q = r / quarter;
    rem = r - q * quarter;
    wide = 128'(rem) * 128'(DEG_RAD);
    x = longint'(wide >> (FB + 2));
    x2 = (x * x) >>> 30;
    wide = 128'(x) * 128'(taylor(x2, 0));
    sv = longint'(wide >> 30);
    cv = taylor(x2, 1);
    case (q)
      0: begin s = sv; c = cv; end
      1: begin s = cv; c = -sv; end
      2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  function automatic longint mul_round(longint a, longint b);
    bit neg;
    logic [127:0] p;
    longint ua, ub;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (128'(ua) * 128'(ub) + (128'd1 << 29)) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic void predict_matrix(item_t it);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    longint rot [3][3];
    row_t r;
    trig(it.ang[0], sx, cx);
    trig(it.ang[1], sy, cy);
    trig(it.ang[2], sz, cz);
    czsy = mul_round(cz, sy);
    szsy = mul_round(sz, sy);
    rot[0][0] = mul_round(cz, cy);
    rot[0][1] = mul_round(czsy, sx) - mul_round(sz, cx);
    rot[0][2] = mul_round(czsy, cx) + mul_round(sz, sx);
    rot[1][0] = mul_round(sz, cy);
    rot[1][1] = mul_round(szsy, sx) + mul_round(cz, cx);
    rot[1][2] = mul_round(szsy, cx) - mul_round(cz, sx);
    rot[2][0] = -sy;
    rot[2][1] = mul_round(cy, sx);
    rot[2][2] = mul_round(cy, cx);
    for (int i = 0; i < 3; i++) begin
      r.row = 2'(i);
      for (int j = 0; j < 3; j++) r.c[j] = clip(mul_round(rot[i][j], it.fac[j]));
      r.c[3] = it.shf[i];
      r.last = 0;
      rows_due.push_back(r);
    end
    r.row = mmb_pkg::ROW_LAST;
    r.c[0] = 0; r.c[1] = 0; r.c[2] = 0;
    r.c[3] = 32'sd1 <<< FB;
    r.last = 1;
    rows_due.push_back(r);
  endfunction

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $signed(32'($urandom_range(0, 720)) << FB) - (32'sd360 <<< FB);
      3: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_item(item_t it);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 0;
      @(negedge clk);
    end
    ax <= it.ang[0]; ay <= it.ang[1]; az <= it.ang[2];
    tx <= it.shf[0]; ty <= it.shf[1]; tz <= it.shf[2];
    fx <= it.fac[0]; fy <= it.fac[1]; fz <= it.fac[2];
    in_valid_i <= 1;
    do @(posedge clk); while (in_stall_o);
    predict_matrix(it);
    sent++;
    @(negedge clk);
  endtask

  function automatic item_t make_item(logic signed [31:0] a0, a1, a2, s, f);
    item_t it;
    for (int k = 0; k < 3; k++) begin
      it.shf[k] = s;
      it.fac[k] = f;
    end
    it.ang[0] = a0; it.ang[1] = a1; it.ang[2] = a2;
    return it;
  endfunction

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] D90 = 32'sd90 <<< 16;

  // directed rows: diag holds the diagonal expected where it is plain to see
  dir_t directed [$];

  initial begin
    dir_t d;
    item_t it;
    d.has_exp = 1;
    d.it = make_item(0, 0, 0, 0, ONE); d.diag = '{ONE, ONE, ONE}; directed.push_back(d);
    d.it = make_item(0, 0, 0, MAXV, MAXV); d.diag = '{MAXV, MAXV, MAXV}; directed.push_back(d);
    d.it = make_item(0, 0, 0, MINV, MINV); d.diag = '{MINV, MINV, MINV}; directed.push_back(d);
    d.it = make_item(32'sd360 <<< 16, -(32'sd720 <<< 16), 0, 0, ONE);
    d.diag = '{ONE, ONE, ONE}; directed.push_back(d);
    d.it = make_item(32'sd180 <<< 16, 0, 0, ONE, ONE);
    d.diag = '{ONE, -ONE, -ONE}; directed.push_back(d);
    d.has_exp = 0;
    d.it = make_item(D90, 0, 0, -ONE, ONE); directed.push_back(d);
    d.it = make_item(0, D90, 0, ONE, ONE); directed.push_back(d);
    d.it = make_item(0, 0, D90, ONE, ONE); directed.push_back(d);
    d.it = make_item(-D90, D90 * 3, 32'sd270 <<< 16, 0, -ONE); directed.push_back(d);
    d.it = make_item(MAXV, MINV, MAXV, MAXV, MAXV); directed.push_back(d);
    d.it = make_item(MINV, MAXV, MINV, MINV, MINV); directed.push_back(d);
    d.it = make_item(32'sd45 <<< 16, 32'sd30 <<< 16, 32'sd60 <<< 16, ONE, MAXV);
    directed.push_back(d);
    d.it = make_item(32'sd1, -32'sd1, 32'sh0059_FFFF, 32'sh1234_5678, MINV);
    directed.push_back(d);
    d.it = make_item(32'sh7FFF_0000, 32'sh8000_FFFF, 32'h5A_0000, -1, ONE * 2);
    directed.push_back(d);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1;
    @(negedge clk);
    foreach (directed[i]) begin
      if (directed[i].has_exp) begin
        row_t r;
        predict_matrix(directed[i].it);
        for (int k = 0; k < 3; k++) begin
          r = rows_due[rows_due.size() - 4 + k];
          if (r.c[k] !== directed[i].diag[k]) begin
            errors++;
            $display("%0t predictor diag row %0d: expected %h actual %h",
                     $time, k, directed[i].diag[k], r.c[k]);
          end
        end
        repeat (4) void'(rows_due.pop_back());
      end
      send_item(directed[i].it);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 100 && n < 160);
      if (n == 200) hold_req = 1;
      for (int k = 0; k < 3; k++) begin
        it.ang[k] = rnd_word();
        it.shf[k] = $signed($urandom());
        it.fac[k] = rnd_word();
      end
      send_item(it);
    end
    in_valid_i <= 0;
    sending_done = 1;
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1;
        for (hold = 0; hold < 150; hold++) @(negedge clk);
      end
      out_stall_i <= (!no_idle && $urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    row_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rows_seen++;
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t unexpected row transfer: actual row %0d", $time, row_index_o);
      end else begin
        e = rows_due.pop_front();
        if (row_index_o !== e.row || last_row_o !== e.last || col0_o !== e.c[0] ||
            col1_o !== e.c[1] || col2_o !== e.c[2] || col3_o !== e.c[3]) begin
          errors++;
          $display("%0t row mismatch: expected %0d %h %h %h %h %b actual %0d %h %h %h %h %b",
                   $time, e.row, e.c[0], e.c[1], e.c[2], e.c[3], e.last,
                   row_index_o, col0_o, col1_o, col2_o, col3_o, last_row_o);
        end
      end
    end
  end

  initial begin
    while (cycles < LIMIT && !(sending_done && rows_due.size() == 0)) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
    end else begin
      repeat (40) @(posedge clk);
      $display("%0d matrices sent, %0d rows checked, incl. angle wrap, 90 degree steps,",
               sent, rows_seen);
      $display("saturating scales, stalls and a long output hold-off");
      if (errors == 0 && rows_due.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end
endmodule

[files.f]
hdl/mmb_pkg.sv
hdl/mmb_angle.sv
hdl/mmb_series.sv
hdl/mmb_rot.sv
hdl/mmb_scale.sv
hdl/model_matrix_builder.sv
sim/testbench.sv
